// File: hw/rtl/tkbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tkbp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [20:0] {
    PH_IDLE     = 21'd1 << 0,
    PH_VER      = 21'd1 << 1,
    PH_USAGE    = 21'd1 << 2,
    PH_FLAGS    = 21'd1 << 3,
    PH_AUTH     = 21'd1 << 4,
    PH_ALG      = 21'd1 << 5,
    PH_ENC      = 21'd1 << 6,
    PH_SIG      = 21'd1 << 7,
    PH_PARM     = 21'd1 << 8,
    PH_BITLEN   = 21'd1 << 9,
    PH_PRIMES   = 21'd1 << 10,
    PH_EXPSIZE  = 21'd1 << 11,
    PH_PARMSKIP = 21'd1 << 12,
    PH_EXP      = 21'd1 << 13,
    PH_EXPSKIP  = 21'd1 << 14,
    PH_PCRSIZE  = 21'd1 << 15,
    PH_PCRDATA  = 21'd1 << 16,
    PH_MODLEN   = 21'd1 << 17,
    PH_MODDATA  = 21'd1 << 18,
    PH_PRIVLEN  = 21'd1 << 19,
    PH_PRIVDATA = 21'd1 << 20
  } phase_t;

  // Field codes carried on the result channel.
  localparam logic [4:0] FC_VERSION  = 5'd0;
  localparam logic [4:0] FC_USAGE    = 5'd1;
  localparam logic [4:0] FC_FLAGS    = 5'd2;
  localparam logic [4:0] FC_AUTH     = 5'd3;
  localparam logic [4:0] FC_ALG      = 5'd4;
  localparam logic [4:0] FC_ENC      = 5'd5;
  localparam logic [4:0] FC_SIG      = 5'd6;
  localparam logic [4:0] FC_PARMSIZE = 5'd7;
  localparam logic [4:0] FC_BITLEN   = 5'd8;
  localparam logic [4:0] FC_PRIMES   = 5'd9;
  localparam logic [4:0] FC_EXPSIZE  = 5'd10;
  localparam logic [4:0] FC_EXPONENT = 5'd11;
  localparam logic [4:0] FC_PCRSIZE  = 5'd12;
  localparam logic [4:0] FC_PCRBYTE  = 5'd13;
  localparam logic [4:0] FC_MODLEN   = 5'd14;
  localparam logic [4:0] FC_MODBYTE  = 5'd15;
  localparam logic [4:0] FC_PRIVLEN  = 5'd16;
  localparam logic [4:0] FC_PRIVBYTE = 5'd17;

  localparam logic [31:0] RSA_ALG        = 32'h0000_0001;
  localparam logic [31:0] DEFAULT_EXP    = 32'd65537;
  localparam logic [31:0] INLINE_EXP_LEN = 32'd3;

  // Result queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [4:0]  code;
    logic [31:0] value;
    logic [9:0]  index;
    logic        done;
    logic [31:0] total;
    logic        run_end;
  } result_t;

  // Up to two results produced by one accepted byte.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

`default_nettype wire

// File: hw/rtl/tkbp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tkbp_parser #(
  parameter int unsigned MAX_PCR_INFO_BYTES    = 256,
  parameter int unsigned MAX_MODULUS_BYTES     = 256,
  parameter int unsigned MAX_PRIVATE_KEY_BYTES = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          blob_start,
  output tkbp_pkg::push_t    push_o
);

  tkbp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        rsa_r, rsa_nxt;
  logic        copy_r, copy_nxt;
  logic [9:0]  pos_r, pos_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  always_comb begin
    logic [31:0] v;
    logic        last;
    logic        done;
    logic [4:0]  bcode;

    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    rsa_nxt   = rsa_r;
    copy_nxt  = copy_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    push_o    = '0;
    v         = {acc_r[23:0], data_byte};
    last      = 1'b0;
    done      = 1'b0;
    bcode     = tkbp_pkg::FC_PCRBYTE;

    if (accept) begin
      if (blob_start) begin
        phase_nxt = tkbp_pkg::PH_VER;
        rem_nxt   = 32'd4;
        acc_nxt   = '0;
        rsa_nxt   = 1'b0;
        copy_nxt  = 1'b0;
        pos_nxt   = '0;
        cnt_nxt   = '0;
      end
      v = {acc_nxt[23:0], data_byte};

      if (phase_nxt != tkbp_pkg::PH_IDLE && cnt_nxt != '1) begin
        cnt_nxt = cnt_nxt + 32'd1;
      end

      unique case (phase_nxt)
        tkbp_pkg::PH_PARMSKIP, tkbp_pkg::PH_EXPSKIP: begin
          rem_nxt = rem_nxt - 32'd1;
          if (rem_nxt == '0) begin
            // Only the non-RSA parameter skip reports the default exponent here.
            if (phase_nxt == tkbp_pkg::PH_PARMSKIP) begin
              push_o.push0    = 1'b1;
              push_o.r0.code  = tkbp_pkg::FC_EXPONENT;
              push_o.r0.value = tkbp_pkg::DEFAULT_EXP;
            end
            phase_nxt = tkbp_pkg::PH_PCRSIZE;
            rem_nxt   = 32'd4;
            acc_nxt   = '0;
          end
        end
        tkbp_pkg::PH_PCRDATA, tkbp_pkg::PH_MODDATA, tkbp_pkg::PH_PRIVDATA: begin
          last = (rem_nxt == 32'd1);
          done = last && (phase_nxt == tkbp_pkg::PH_PRIVDATA);
          if (phase_nxt == tkbp_pkg::PH_MODDATA) begin
            bcode = tkbp_pkg::FC_MODBYTE;
          end else if (phase_nxt == tkbp_pkg::PH_PRIVDATA) begin
            bcode = tkbp_pkg::FC_PRIVBYTE;
          end
          if (copy_nxt) begin
            push_o.push0    = 1'b1;
            push_o.r0.code  = bcode;
            push_o.r0.value = {24'd0, data_byte};
            push_o.r0.index = pos_nxt;
            push_o.r0.done  = done;
          end else if (done) begin
            // The accumulator still holds the private key length here.
            push_o.push0    = 1'b1;
            push_o.r0.code  = tkbp_pkg::FC_PRIVLEN;
            push_o.r0.value = acc_nxt;
            push_o.r0.done  = 1'b1;
          end
          pos_nxt = pos_nxt + 10'd1;
          rem_nxt = rem_nxt - 32'd1;
          if (last) begin
            acc_nxt = '0;
            if (phase_nxt == tkbp_pkg::PH_PCRDATA) begin
              phase_nxt = tkbp_pkg::PH_MODLEN;
              rem_nxt   = 32'd4;
            end else if (phase_nxt == tkbp_pkg::PH_MODDATA) begin
              phase_nxt = tkbp_pkg::PH_PRIVLEN;
              rem_nxt   = 32'd4;
            end else begin
              phase_nxt = tkbp_pkg::PH_IDLE;
              rem_nxt   = '0;
            end
          end
        end
        tkbp_pkg::PH_VER, tkbp_pkg::PH_USAGE, tkbp_pkg::PH_FLAGS, tkbp_pkg::PH_AUTH,
        tkbp_pkg::PH_ALG, tkbp_pkg::PH_ENC, tkbp_pkg::PH_SIG, tkbp_pkg::PH_PARM,
        tkbp_pkg::PH_BITLEN, tkbp_pkg::PH_PRIMES, tkbp_pkg::PH_EXPSIZE, tkbp_pkg::PH_EXP,
        tkbp_pkg::PH_PCRSIZE, tkbp_pkg::PH_MODLEN, tkbp_pkg::PH_PRIVLEN: begin
          acc_nxt = v;
          rem_nxt = rem_nxt - 32'd1;
          if (rem_nxt == '0) begin
            push_o.push0    = 1'b1;
            push_o.r0.value = v;
            acc_nxt         = '0;
            rem_nxt         = 32'd4;
            unique case (phase_nxt)
              tkbp_pkg::PH_VER: begin
                push_o.r0.code = tkbp_pkg::FC_VERSION;
                phase_nxt      = tkbp_pkg::PH_USAGE;
                rem_nxt        = 32'd2;
              end
              tkbp_pkg::PH_USAGE: begin
                push_o.r0.code = tkbp_pkg::FC_USAGE;
                phase_nxt      = tkbp_pkg::PH_FLAGS;
              end
              tkbp_pkg::PH_FLAGS: begin
                push_o.r0.code = tkbp_pkg::FC_FLAGS;
                phase_nxt      = tkbp_pkg::PH_AUTH;
                rem_nxt        = 32'd1;
              end
              tkbp_pkg::PH_AUTH: begin
                push_o.r0.code = tkbp_pkg::FC_AUTH;
                phase_nxt      = tkbp_pkg::PH_ALG;
              end
              tkbp_pkg::PH_ALG: begin
                push_o.r0.code = tkbp_pkg::FC_ALG;
                rsa_nxt        = (v == tkbp_pkg::RSA_ALG);
                phase_nxt      = tkbp_pkg::PH_ENC;
                rem_nxt        = 32'd2;
              end
              tkbp_pkg::PH_ENC: begin
                push_o.r0.code = tkbp_pkg::FC_ENC;
                phase_nxt      = tkbp_pkg::PH_SIG;
                rem_nxt        = 32'd2;
              end
              tkbp_pkg::PH_SIG: begin
                push_o.r0.code = tkbp_pkg::FC_SIG;
                phase_nxt      = tkbp_pkg::PH_PARM;
              end
              tkbp_pkg::PH_PARM: begin
                push_o.r0.code = tkbp_pkg::FC_PARMSIZE;
                if (rsa_nxt && v != '0) begin
                  phase_nxt = tkbp_pkg::PH_BITLEN;
                end else if (v != '0) begin
                  phase_nxt = tkbp_pkg::PH_PARMSKIP;
                  rem_nxt   = v;
                end else begin
                  push_o.push1    = 1'b1;
                  push_o.r1.code  = tkbp_pkg::FC_EXPONENT;
                  push_o.r1.value = tkbp_pkg::DEFAULT_EXP;
                  phase_nxt       = tkbp_pkg::PH_PCRSIZE;
                end
              end
              tkbp_pkg::PH_BITLEN: begin
                push_o.r0.code = tkbp_pkg::FC_BITLEN;
                phase_nxt      = tkbp_pkg::PH_PRIMES;
              end
              tkbp_pkg::PH_PRIMES: begin
                push_o.r0.code = tkbp_pkg::FC_PRIMES;
                phase_nxt      = tkbp_pkg::PH_EXPSIZE;
              end
              tkbp_pkg::PH_EXPSIZE: begin
                push_o.r0.code = tkbp_pkg::FC_EXPSIZE;
                if (v == tkbp_pkg::INLINE_EXP_LEN) begin
                  phase_nxt = tkbp_pkg::PH_EXP;
                  rem_nxt   = tkbp_pkg::INLINE_EXP_LEN;
                end else if (v != '0) begin
                  phase_nxt = tkbp_pkg::PH_EXPSKIP;
                  rem_nxt   = v;
                end else begin
                  push_o.push1    = 1'b1;
                  push_o.r1.code  = tkbp_pkg::FC_EXPONENT;
                  push_o.r1.value = tkbp_pkg::DEFAULT_EXP;
                  phase_nxt       = tkbp_pkg::PH_PCRSIZE;
                end
              end
              tkbp_pkg::PH_EXP: begin
                push_o.r0.code = tkbp_pkg::FC_EXPONENT;
                phase_nxt      = tkbp_pkg::PH_PCRSIZE;
              end
              tkbp_pkg::PH_PCRSIZE: begin
                push_o.r0.code = tkbp_pkg::FC_PCRSIZE;
                if (v == '0) begin
                  phase_nxt = tkbp_pkg::PH_MODLEN;
                end else begin
                  phase_nxt = tkbp_pkg::PH_PCRDATA;
                  rem_nxt   = v;
                  acc_nxt   = v;
                  copy_nxt  = (v <= 32'(MAX_PCR_INFO_BYTES));
                  pos_nxt   = '0;
                end
              end
              tkbp_pkg::PH_MODLEN: begin
                push_o.r0.code = tkbp_pkg::FC_MODLEN;
                if (v == '0) begin
                  phase_nxt = tkbp_pkg::PH_PRIVLEN;
                end else begin
                  phase_nxt = tkbp_pkg::PH_MODDATA;
                  rem_nxt   = v;
                  acc_nxt   = v;
                  copy_nxt  = (v <= 32'(MAX_MODULUS_BYTES));
                  pos_nxt   = '0;
                end
              end
              tkbp_pkg::PH_PRIVLEN: begin
                push_o.r0.code = tkbp_pkg::FC_PRIVLEN;
                if (v == '0) begin
                  push_o.r0.done = 1'b1;
                  phase_nxt      = tkbp_pkg::PH_IDLE;
                  rem_nxt        = '0;
                end else begin
                  phase_nxt = tkbp_pkg::PH_PRIVDATA;
                  rem_nxt   = v;
                  acc_nxt   = v;
                  copy_nxt  = (v <= 32'(MAX_PRIVATE_KEY_BYTES));
                  pos_nxt   = '0;
                end
              end
              default: begin
                phase_nxt = tkbp_pkg::PH_IDLE;
                rem_nxt   = '0;
              end
            endcase
          end
        end
        default: begin
        end
      endcase

      push_o.r0.total = push_o.r0.done ? cnt_nxt : '0;
      if (push_o.push1) begin
        push_o.r1.run_end = 1'b1;
      end else begin
        push_o.r0.run_end = push_o.push0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tkbp_pkg::PH_IDLE;
      rem_r   <= '0;
      acc_r   <= '0;
      rsa_r   <= 1'b0;
      copy_r  <= 1'b0;
      pos_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      acc_r   <= acc_nxt;
      rsa_r   <= rsa_nxt;
      copy_r  <= copy_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !blob_start && phase_r == tkbp_pkg::PH_IDLE) |-> !push_o.push0)
    else $error("result produced by a byte outside a blob");

  a_second_is_exponent: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.push1 |-> (push_o.push0 && push_o.r1.code == tkbp_pkg::FC_EXPONENT
                      && push_o.r1.value == tkbp_pkg::DEFAULT_EXP))
    else $error("second result of a beat is not the default exponent");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push_o.push0 && push_o.r0.done) |=> phase_r == tkbp_pkg::PH_IDLE)
    else $error("parser did not go idle after the end of the key");

endmodule

`default_nettype wire

// File: hw/rtl/tkbp_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tkbp_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tkbp_pkg::push_t   push_i,
  output logic                   has_room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tkbp_pkg::result_t      head
);

  tkbp_pkg::result_t                    q_r [tkbp_pkg::QUEUE_DEPTH];
  logic [tkbp_pkg::PTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [tkbp_pkg::PTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [tkbp_pkg::CNT_W-1:0]           count_r, count_nxt;
  logic                                 pop;
  logic [tkbp_pkg::PTR_W-1:0]           wr_ptr_p1;

  // Room for a two-result beat, judged from registered state only.
  assign has_room  = count_r <= tkbp_pkg::CNT_W'(tkbp_pkg::QUEUE_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = q_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + tkbp_pkg::PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + tkbp_pkg::PTR_W'(push_i.push0) + tkbp_pkg::PTR_W'(push_i.push1);
    rd_ptr_nxt = rd_ptr_r + tkbp_pkg::PTR_W'(pop);
    count_nxt  = count_r + tkbp_pkg::CNT_W'(push_i.push0) + tkbp_pkg::CNT_W'(push_i.push1)
                 - tkbp_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_i.push0) begin
      q_r[wr_ptr_r] <= push_i.r0;
    end
    if (push_i.push1) begin
      q_r[wr_ptr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tkbp_pkg::CNT_W'(tkbp_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_i.push0 |-> has_room)
    else $error("results pushed while the queue lacked room");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push_i.push1 |-> push_i.push0)
    else $error("second result pushed without the first");

endmodule

`default_nettype wire

// File: hw/rtl/tpm_key_blob_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  data_byte, blob_start
// out_      output     out_valid/out_stall  field_code, field_value, byte_index,
//                                           key_done, total_length, run_end
//
// A byte is parsed in the cycle it is accepted; its results are registered in the queue.
// One byte can be taken every cycle while the four-entry result queue holds two or fewer.
// Bytes that finish a zero parameter or exponent size give two results, so they fill two
// queue entries; all other bytes give at most one result each.
// Reset is synchronous: the parser returns to idle and the queue is emptied.
// out_stall never reaches in_stall combinationally; in_stall follows the queue fill level.

module tpm_key_blob_parser #(
  parameter int unsigned MAX_PCR_INFO_BYTES    = 256,
  parameter int unsigned MAX_MODULUS_BYTES     = 256,
  parameter int unsigned MAX_PRIVATE_KEY_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_blob_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_field_code,
  output logic [31:0]      out_field_value,
  output logic [9:0]       out_byte_index,
  output logic             out_key_done,
  output logic [31:0]      out_total_length,
  output logic             out_run_end
);

  tkbp_pkg::push_t   push;
  tkbp_pkg::result_t head;
  logic              has_room;
  logic              accept;

  assign in_stall = !has_room;
  assign accept   = in_valid && has_room;

  tkbp_parser #(
    .MAX_PCR_INFO_BYTES    (MAX_PCR_INFO_BYTES),
    .MAX_MODULUS_BYTES     (MAX_MODULUS_BYTES),
    .MAX_PRIVATE_KEY_BYTES (MAX_PRIVATE_KEY_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .blob_start (in_blob_start),
    .push_o     (push)
  );

  tkbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_field_code   = head.code;
  assign out_field_value  = head.value;
  assign out_byte_index   = head.index;
  assign out_key_done     = head.done;
  assign out_total_length = head.total;
  assign out_run_end      = head.run_end;

endmodule

`default_nettype wire
